// ===== rtl/fic_pkg.sv =====
// Shared types and constants for the FIFO with class dequeue.
// No dependencies; imported by the cell and the top level.
package fic_pkg;

    typedef enum logic [1:0] {
        OP_ENQ     = 2'd0,
        OP_DEQ     = 2'd1,
        OP_DEQ_C   = 2'd2,
        OP_DEQ_D   = 2'd3
    } op_t;

    localparam logic [7:0] CLASS_C = 8'h63;
    localparam logic [7:0] CLASS_D = 8'h64;

    // Broadcast from the top level to every cell for one accepted request.
    typedef struct packed {
        logic       enq;    // enqueue accepted and queue not full
        logic       cls;    // class dequeue accepted
        logic [7:0] want;   // class byte searched for
    } cell_ctrl_t;

endpackage

// ===== rtl/fic_cell.sv =====
// One storage cell of the queue chain: holds one byte and shifts toward the head.
// Depends on fic_pkg.
module fic_cell
    import fic_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       tail,
    input  logic [7:0] item_value,
    input  logic       seen_in,
    input  logic [7:0] right_data,
    output logic       seen_out,
    output logic [7:0] data,
    output logic [7:0] data_next
);

    logic [7:0] data_reg;
    logic       match_here;

    // A removal point at or before this cell makes it take its neighbor's byte.
    assign match_here = occupied && ctrl.cls && (data_reg == ctrl.want);
    assign seen_out   = seen_in || match_here;

    always_comb
    begin
        if (seen_out)
        begin
            data_next = right_data;
        end
        else if (ctrl.enq && tail)
        begin
            data_next = item_value;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/fifo_with_class_dequeue.sv =====
// FIFO of bytes with removal of the oldest entry of a class, built as a chain of cells.
// The result of a request is captured in the output registers when it is accepted.
// Throughput: one request per cycle unless the output stalls; match and shift across
// the cell chain are combinational. Reset clears the entry count and the output valid;
// the cell bytes are not cleared, since only cells below the count are ever used.
// Depends on fic_pkg and fic_cell.
module fifo_with_class_dequeue
    import fic_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [7:0] item_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_value,
    output logic       found,
    output logic       dropped,
    output logic       empty_after,
    output logic [7:0] front_after,
    output logic [4:0] count_after
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // The count register is the only control state of the queue: cell i holds an
    // entry exactly when i is below the count, and cell count is the enqueue slot.
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic       out_valid_reg;
    logic [7:0] out_value_reg;
    logic       found_reg;
    logic       dropped_reg;
    logic       empty_after_reg;
    logic [7:0] front_after_reg;
    logic [4:0] count_after_reg;

    logic       step;
    op_t        op;
    logic       is_full;
    logic       is_empty;
    logic       front_rm;
    logic       hit;
    logic       res_found;
    logic       res_dropped;
    logic [7:0] res_value;
    cell_ctrl_t ctrl;

    logic [DEPTH:0]   seen;
    logic [7:0]       cell_data [DEPTH];
    logic [7:0]       cell_next [DEPTH];

    // The output register parts the two sides: a new request is taken whenever the
    // pending result is absent or is being taken in this same cycle.
    assign in_stall = out_valid_reg && out_stall;
    assign step     = in_valid && !in_stall;
    assign op       = op_t'(opcode);
    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        ctrl.enq  = step && (op == OP_ENQ) && !is_full;
        ctrl.cls  = step && ((op == OP_DEQ_C) || (op == OP_DEQ_D));
        ctrl.want = (op == OP_DEQ_C) ? CLASS_C : CLASS_D;
    end

    // Removing the head starts the shift at cell zero; a class dequeue starts it at
    // the first occupied cell whose byte matches, found by the rippling seen chain.
    assign front_rm = step && (op == OP_DEQ) && !is_empty;
    assign seen[0]  = front_rm;
    assign hit      = seen[DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [7:0] right_data;
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_data = cell_data[gi];
            end
            else
            begin : g_mid
                assign right_data = cell_data[gi + 1];
            end

            fic_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (CW'(gi) < count_reg),
                .tail       (CW'(gi) == count_reg),
                .item_value (item_value),
                .seen_in    (seen[gi]),
                .right_data (right_data),
                .seen_out   (seen[gi + 1]),
                .data       (cell_data[gi]),
                .data_next  (cell_next[gi])
            );
        end
    endgenerate

    // A class dequeue removes a byte equal to the class itself, so the removed
    // value needs no search across the cells.
    assign res_found   = hit;
    assign res_dropped = step && (op == OP_ENQ) && is_full;

    always_comb
    begin
        if (front_rm)
        begin
            res_value = cell_data[0];
        end
        else if (hit)
        begin
            res_value = ctrl.want;
        end
        else
        begin
            res_value = 8'd0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (res_found)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_value_reg   <= res_value;
            found_reg       <= res_found;
            dropped_reg     <= res_dropped;
            empty_after_reg <= (count_next == '0);
            front_after_reg <= (count_next == '0) ? 8'd0 : cell_next[0];
            count_after_reg <= 5'(count_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign found       = found_reg;
    assign dropped     = dropped_reg;
    assign empty_after = empty_after_reg;
    assign front_after = front_after_reg;
    assign count_after = count_after_reg;

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above depth");

    // A removal lowers the count by exactly one in the next cycle.
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_found |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("removal did not lower the count by one");

    // A dropped enqueue leaves the count unchanged.
    a_drop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_dropped |=> (count_reg == $past(count_reg)))
        else $error("dropped enqueue changed the count");

    // A request can only be taken while no result is held back by the output side.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !step)
        else $error("request accepted while result stalled");

endmodule
